/* rtl/rrot_pkg.sv */
// Package with constants, codes and helper functions of the render rate overload throttle.
package rrot_pkg;

    localparam int MAX_SUBFRAMES = 4;
    localparam int EMA_SHIFT     = 5;
    localparam int FRAC_BITS     = 10;
    localparam int SUB_W         = $clog2(MAX_SUBFRAMES + 1);
    localparam int DUR_W         = 20;
    localparam int EMA_W         = DUR_W + FRAC_BITS;
    localparam int FPS_W         = 10;
    localparam int CNT_W         = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 20;

    localparam logic [EMA_W-1:0]  EMA_RESET       = EMA_W'(16667) << FRAC_BITS;
    localparam logic [DUR_W-1:0]  EMA_LIMIT_RESET = DUR_W'(17400);
    localparam logic [CNT_W-1:0]  OVERRUN_RESET   = CNT_W'(90);
    localparam logic [CNT_W-1:0]  WARMUP_RESET    = CNT_W'(120);
    localparam logic [CNT_W-1:0]  CNT_MAX         = {CNT_W{1'b1}};
    localparam logic [EMA_W:0]    EMA_ROUND       = (EMA_W + 1)'((1 << EMA_SHIFT) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REQUESTED_FPS = 3'd0,
        REG_FORCE_DISABLE = 3'd1,
        REG_EMA_LIMIT_US  = 3'd2,
        REG_OVERRUN_LIMIT = 3'd3,
        REG_WARMUP_TICKS  = 3'd4
    } cfg_index_t;

    localparam logic ACT_QUERY = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // The requested count is (fps + 30) / 60, clamped to 1..MAX_SUBFRAMES.
    function automatic logic [SUB_W-1:0] requested_count(input logic [FPS_W-1:0] fps);
        logic [SUB_W-1:0] k;
        begin
            k = SUB_W'(1);
            for (int m = 2; m <= MAX_SUBFRAMES; m++)
            begin
                if ({1'b0, fps} >= (FPS_W + 1)'(60 * m - 30))
                begin
                    k = SUB_W'(m);
                end
            end
            return k;
        end
    endfunction

endpackage

/* rtl/render_rate_overload_throttle.sv */
// Top level of the render rate overload throttle: state, update logic and result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready   | action, tick_micros, trace_active
//  out     | output    | out_valid / out_ready | subframes, cap_now, average_us, stepped_down
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// Each request is processed in the cycle it is accepted and its result is held in the
// output register from the next cycle on, so one request per cycle is sustained while the output is drained.
// A new request is taken whenever the output register is empty or is being drained.
// A stall on the output side holds the result and blocks only further requests.
// Reset puts the configuration and throttle state at their documented reset values.
module render_rate_overload_throttle
    import rrot_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [DUR_W-1:0]      tick_micros,
    input  logic                  trace_active,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SUB_W-1:0]      subframes,
    output logic [SUB_W-1:0]      cap_now,
    output logic [DUR_W-1:0]      average_us,
    output logic                  stepped_down
);

    logic [FPS_W-1:0] fps_reg;
    logic             force_reg;
    logic [DUR_W-1:0] limit_reg;
    logic [CNT_W-1:0] overrun_limit_reg;
    logic [CNT_W-1:0] warmup_ticks_reg;

    logic [EMA_W-1:0] smoothed_reg, smoothed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] warmup_reg, warmup_next;
    logic [SUB_W-1:0] cap_reg, cap_next;
    logic [SUB_W-1:0] applied_reg, applied_next;
    logic             stepped_next;

    logic             out_valid_reg;
    logic [SUB_W-1:0] sub_out_reg;
    logic [SUB_W-1:0] cap_out_reg;
    logic [DUR_W-1:0] avg_out_reg;
    logic             stepped_out_reg;

    logic             accept;
    logic             rearm;
    logic [SUB_W-1:0] req_count;
    logic [EMA_W-1:0] target;
    logic [EMA_W-1:0] up_diff;
    logic [EMA_W-1:0] dn_diff;
    logic [EMA_W:0]   dn_round;
    logic [EMA_W:0]   dn_step;
    logic [EMA_W-1:0] ema_new;
    logic [CNT_W-1:0] count_inc;
    logic             overrun;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign req_count = requested_count(fps_reg);
    assign target    = {tick_micros, {FRAC_BITS{1'b0}}};
    assign up_diff   = target - smoothed_reg;
    assign dn_diff   = smoothed_reg - target;
    assign dn_round  = {1'b0, dn_diff} + EMA_ROUND;
    assign dn_step   = dn_round >> EMA_SHIFT;
    assign ema_new   = (target >= smoothed_reg) ? smoothed_reg + (up_diff >> EMA_SHIFT)
                                                : smoothed_reg - dn_step[EMA_W-1:0];
    assign overrun   = ema_new > {limit_reg, {FRAC_BITS{1'b0}}};
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + CNT_W'(1);

    always_comb
    begin
        smoothed_next = smoothed_reg;
        count_next    = count_reg;
        warmup_next   = warmup_reg;
        cap_next      = cap_reg;
        applied_next  = applied_reg;
        stepped_next  = 1'b0;
        if (action == ACT_QUERY)
        begin
            if (force_reg || req_count <= SUB_W'(1) || trace_active)
            begin
                applied_next = SUB_W'(1);
            end
            else
            begin
                applied_next = (req_count < cap_reg) ? req_count : cap_reg;
            end
        end
        else
        begin
            smoothed_next = ema_new;
            if (applied_reg <= SUB_W'(1))
            begin
                count_next = '0;
            end
            else if (warmup_reg != '0)
            begin
                warmup_next = warmup_reg - CNT_W'(1);
            end
            else if (overrun)
            begin
                count_next = count_inc;
                if (count_inc >= overrun_limit_reg)
                begin
                    cap_next     = applied_reg - SUB_W'(1);
                    count_next   = '0;
                    warmup_next  = warmup_ticks_reg;
                    stepped_next = 1'b1;
                end
            end
            else
            begin
                count_next = '0;
            end
        end
    end

    always_comb
    begin
        rearm = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_REQUESTED_FPS, REG_FORCE_DISABLE, REG_EMA_LIMIT_US,
                REG_OVERRUN_LIMIT, REG_WARMUP_TICKS: rearm = 1'b1;
                default:                             rearm = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg           <= '0;
            force_reg         <= 1'b0;
            limit_reg         <= EMA_LIMIT_RESET;
            overrun_limit_reg <= OVERRUN_RESET;
            warmup_ticks_reg  <= WARMUP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_REQUESTED_FPS: fps_reg           <= cfg_data[FPS_W-1:0];
                REG_FORCE_DISABLE: force_reg         <= cfg_data[0];
                REG_EMA_LIMIT_US:  limit_reg         <= cfg_data[DUR_W-1:0];
                REG_OVERRUN_LIMIT: overrun_limit_reg <= cfg_data[CNT_W-1:0];
                REG_WARMUP_TICKS:  warmup_ticks_reg  <= cfg_data[CNT_W-1:0];
                default:           fps_reg           <= fps_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg <= EMA_RESET;
            count_reg    <= '0;
            warmup_reg   <= WARMUP_RESET;
            cap_reg      <= SUB_W'(MAX_SUBFRAMES);
            applied_reg  <= SUB_W'(1);
        end
        else if (rearm)
        begin
            // A configuration write restarts the throttle; the applied count is kept.
            smoothed_reg <= EMA_RESET;
            count_reg    <= '0;
            warmup_reg   <= (cfg_index_t'(cfg_index) == REG_WARMUP_TICKS) ?
                            cfg_data[CNT_W-1:0] : warmup_ticks_reg;
            cap_reg      <= SUB_W'(MAX_SUBFRAMES);
        end
        else if (accept)
        begin
            smoothed_reg <= smoothed_next;
            count_reg    <= count_next;
            warmup_reg   <= warmup_next;
            cap_reg      <= cap_next;
            applied_reg  <= applied_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sub_out_reg     <= applied_next;
            cap_out_reg     <= cap_next;
            avg_out_reg     <= smoothed_next[EMA_W-1:FRAC_BITS];
            stepped_out_reg <= stepped_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign subframes    = sub_out_reg;
    assign cap_now      = cap_out_reg;
    assign average_us   = avg_out_reg;
    assign stepped_down = stepped_out_reg;

    // A step down leaves the cap exactly one below the count that was applied.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stepped_down |-> cap_now == subframes - SUB_W'(1))
        else $error("Step down did not set the cap to one below the applied count.");

    // A query never steps down and never applies more subframes than the cap allows, except the forced single one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == ACT_QUERY |=> !stepped_down &&
            (subframes == SUB_W'(1) || subframes <= cap_now))
        else $error("Query result exceeds the throttle cap.");

    // The cap and the applied count never fall to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg != '0 && applied_reg != '0)
        else $error("Cap or applied count reached zero.");

    // An accepted request always shows a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("Accepted request produced no result.");

endmodule
